@@ src/mdn_pkg.sv @@
// Shared types, register codes and arithmetic helpers of the midpoint displacement noise source.
// No dependencies; used by midpoint_displacement_noise.
package mdn_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RG_TAIL,
		ST_RG_HEAD,
		ST_RG_MID,
		ST_RG_END,
		ST_MID_RDL,
		ST_MID_RDR,
		ST_MID_WR,
		ST_SCALE,
		ST_ADD_RD,
		ST_ADD_MUL,
		ST_ADD_WR,
		ST_SERVE
	} state_t;

	typedef struct packed {
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] s3;
	} gen_t;

	localparam logic [2:0] REG_MASK_BITS     = 3'd0;
	localparam logic [2:0] REG_OVERFLOW_MODE = 3'd1;
	localparam logic [2:0] REG_HURST_FACTOR  = 3'd2;
	localparam logic [2:0] REG_SEED_ONE      = 3'd3;
	localparam logic [2:0] REG_SEED_TWO      = 3'd4;
	localparam logic [2:0] REG_SEED_THREE    = 3'd5;

	localparam logic [1:0] OVF_SATURATE = 2'd1;
	localparam logic [1:0] OVF_WRAP     = 2'd3;

	localparam logic [31:0] SEED_RESET  = 32'd12345;
	localparam logic [16:0] HURST_RESET = 17'd46341;
	localparam logic [16:0] HURST_ONE   = 17'd65536;
	localparam logic [31:0] SCALE_HALF  = 32'h8000_0000;

	// One Taus88 step on all three components.
	function automatic gen_t taus_next(input gen_t g);
		gen_t n;
		logic [31:0] b;
		b    = ((g.s1 << 13) ^ g.s1) >> 19;
		n.s1 = ((g.s1 & 32'hFFFF_FFFE) << 12) ^ b;
		b    = ((g.s2 << 2) ^ g.s2) >> 25;
		n.s2 = ((g.s2 & 32'hFFFF_FFF8) << 4) ^ b;
		b    = ((g.s3 << 3) ^ g.s3) >> 11;
		n.s3 = ((g.s3 & 32'hFFFF_FFF0) << 17) ^ b;
		return n;
	endfunction

	function automatic logic [31:0] taus_word(input gen_t g);
		return g.s1 ^ g.s2 ^ g.s3;
	endfunction

	// Signed divide by four, truncating toward zero.
	function automatic logic [31:0] quarter(input logic [31:0] x);
		logic signed [31:0] t;
		t = $signed(x) + (x[31] ? 32'sd3 : 32'sd0);
		return 32'(t >>> 2);
	endfunction

	// Signed divide by two, truncating toward zero.
	function automatic logic [31:0] half(input logic [31:0] x);
		logic signed [31:0] t;
		t = $signed(x) + $signed({31'd0, x[31]});
		return 32'(t >>> 1);
	endfunction

	// Fold a 34-bit signed sum back into 32 bits by the overflow mode.
	function automatic logic [31:0] resolve(input logic [33:0] t, input logic [1:0] mode);
		logic ovf;
		logic [31:0] r;
		ovf = !((t[33:31] == 3'b000) || (t[33:31] == 3'b111));
		if (!ovf) begin
			r = t[31:0];
		end else begin
			case (mode)
				OVF_SATURATE: r = t[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				OVF_WRAP:     r = t[31:0];
				default:      r = 32'h8000_0000;
			endcase
		end
		return r;
	endfunction

	// Clear the low nn bits and add the centering offset.
	function automatic logic [31:0] mask_sample(input logic [31:0] s, input logic [4:0] nn);
		logic [31:0] m;
		m = 32'hFFFF_FFFF << nn;
		return (nn == 5'd0) ? s : ((s & m) + ((~m) >> 1));
	endfunction

endpackage

@@ src/midpoint_displacement_noise.sv @@
// Fractal noise source by midpoint displacement: sequencer, noise buffer and output stage.
// Depends on mdn_pkg (state type, generator type, register codes, arithmetic helpers).
//
// Usage:
//   Input channel (in_valid/in_ready, vector_size) requests a vector of 1 to MAX_VECTOR
//   samples; a size of zero is taken and yields nothing. Output channel
//   (out_valid/out_ready, sample, last) returns one transfer per sample, last high on the
//   final one. Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready and must only be used while the block is idle.
//   Serving: one buffer read per cycle while the receiver keeps out_ready high; the single
//   read port sets this rate.
//   Regeneration: when a vector would run past the end of the buffer it is rebuilt first,
//   read-modify-write through the same port: each level scales once, each midpoint reads
//   its two neighbours and is written, each displaced entry is read, multiplied, written.
//   in_ready is high only in the idle state; a waiting result does not block the next
//   request, as the output register parts the two sides.
//   Stall: while out_ready is low the output register and the read stage hold, and reads
//   stop until the stage drains.
//   Reset: registers return to their reset values and the read position points at the end,
//   so the first request always regenerates. The buffer needs no clearing pass: only its
//   last entry is read before being written, and a flag stands in for it until then.
module midpoint_displacement_noise #(
	parameter int BUFFER_SPAN = 4096,
	parameter int MAX_VECTOR  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  vector_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sample,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW    = $clog2(BUFFER_SPAN + 1);
	localparam int WW    = AW + 2;
	localparam int LIMIT = (MAX_VECTOR < BUFFER_SPAN) ? MAX_VECTOR : BUFFER_SPAN;
	localparam logic [WW-1:0] SPAN_W = WW'(BUFFER_SPAN);
	localparam logic [AW-1:0] ADDR_END = AW'(BUFFER_SPAN);
	localparam logic [AW-1:0] ADDR_MID = AW'(BUFFER_SPAN / 2);
	localparam logic [AW-1:0] OFS_TOP  = AW'(BUFFER_SPAN / 4);

	// Noise buffer, one read and one write port.
	logic [31:0] buffer_mem [0:BUFFER_SPAN];
	logic        ren;
	logic [AW-1:0] raddr;
	logic [31:0] rdata_q;
	logic        wen;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;

	mdn_pkg::state_t state_q, state_d;

	// Configuration and generator.
	logic [4:0]  mask_q;
	logic [1:0]  mode_q;
	logic [16:0] hurst_q;
	mdn_pkg::gen_t gen_q;
	logic        draw;

	// Regeneration registers.
	logic [31:0]   scale_q;
	logic [AW-1:0] offset_q;
	logic [WW-1:0] idx_q;
	logic [31:0]   left_q;
	logic [31:0]   rand_q;
	logic [31:0]   prod_q;
	logic          tail_valid_q;

	// Serving registers.
	logic [AW-1:0] pos_q;
	logic [6:0]    n_q;
	logic [6:0]    iss_q;
	logic          s1_valid_q;
	logic          s1_last_q;
	logic          out_valid_q;
	logic [31:0]   sample_q;
	logic          last_q;

	logic [6:0]    n_in;
	logic [16:0]   hf;
	logic [48:0]   scale_prod;
	logic [63:0]   rand_prod;
	logic [31:0]   rand_mag;
	logic [33:0]   add_sum;
	logic [31:0]   new_word;
	logic [WW-1:0] mid_next;
	logic [WW-1:0] add_next;
	logic          s1_move;
	logic          serve_ren;

	assign in_ready  = (state_q == mdn_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

	// Clamp the request size and the Hurst factor.
	assign n_in = (vector_size > 7'(LIMIT)) ? 7'(LIMIT) : vector_size;
	assign hf   = (hurst_q > mdn_pkg::HURST_ONE) ? mdn_pkg::HURST_ONE : hurst_q;

	assign new_word   = mdn_pkg::taus_word(mdn_pkg::taus_next(gen_q));
	assign scale_prod = 49'(scale_q) * 49'(hf);
	assign rand_mag   = rand_q[31] ? (~rand_q + 32'd1) : rand_q;
	assign rand_prod  = 64'(rand_mag) * 64'(scale_q);
	assign add_sum    = {{2{rdata_q[31]}}, rdata_q}
		+ (rand_q[31] ? (~{2'b00, prod_q} + 34'd1) : {2'b00, prod_q});
	assign mid_next   = idx_q + WW'({offset_q, 1'b0});
	assign add_next   = idx_q + WW'(offset_q);

	assign s1_move   = s1_valid_q && (!out_valid_q || out_ready);
	assign serve_ren = (state_q == mdn_pkg::ST_SERVE) && (iss_q != n_q)
		&& (!s1_valid_q || s1_move);

	always_ff @(posedge clk) begin
		if (wen) begin
			buffer_mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= buffer_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d = state_q;
		ren     = 1'b0;
		raddr   = '0;
		wen     = 1'b0;
		waddr   = '0;
		wdata   = '0;
		draw    = 1'b0;
		case (state_q)
			mdn_pkg::ST_IDLE: begin
				if (in_valid && n_in != 7'd0) begin
					if (WW'(pos_q) + WW'(n_in) > SPAN_W) begin
						state_d = mdn_pkg::ST_RG_TAIL;
					end else begin
						state_d = mdn_pkg::ST_SERVE;
					end
				end
			end
			mdn_pkg::ST_RG_TAIL: begin
				ren     = tail_valid_q;
				raddr   = ADDR_END;
				state_d = mdn_pkg::ST_RG_HEAD;
			end
			mdn_pkg::ST_RG_HEAD: begin
				wen     = 1'b1;
				waddr   = '0;
				wdata   = tail_valid_q ? rdata_q : 32'd0;
				state_d = mdn_pkg::ST_RG_MID;
			end
			mdn_pkg::ST_RG_MID: begin
				draw    = 1'b1;
				wen     = 1'b1;
				waddr   = ADDR_MID;
				wdata   = mdn_pkg::quarter(new_word);
				state_d = mdn_pkg::ST_RG_END;
			end
			mdn_pkg::ST_RG_END: begin
				draw    = 1'b1;
				wen     = 1'b1;
				waddr   = ADDR_END;
				wdata   = mdn_pkg::quarter(new_word);
				state_d = mdn_pkg::ST_MID_RDL;
			end
			mdn_pkg::ST_MID_RDL: begin
				ren     = 1'b1;
				raddr   = AW'(idx_q - WW'(offset_q));
				state_d = mdn_pkg::ST_MID_RDR;
			end
			mdn_pkg::ST_MID_RDR: begin
				ren     = 1'b1;
				raddr   = AW'(idx_q + WW'(offset_q));
				state_d = mdn_pkg::ST_MID_WR;
			end
			mdn_pkg::ST_MID_WR: begin
				wen   = 1'b1;
				waddr = AW'(idx_q);
				wdata = left_q + mdn_pkg::half(rdata_q);
				if (mid_next + WW'(offset_q) > SPAN_W) begin
					state_d = mdn_pkg::ST_SCALE;
				end else begin
					state_d = mdn_pkg::ST_MID_RDL;
				end
			end
			mdn_pkg::ST_SCALE: begin
				state_d = mdn_pkg::ST_ADD_RD;
			end
			mdn_pkg::ST_ADD_RD: begin
				ren     = 1'b1;
				raddr   = AW'(idx_q);
				draw    = 1'b1;
				state_d = mdn_pkg::ST_ADD_MUL;
			end
			mdn_pkg::ST_ADD_MUL: begin
				state_d = mdn_pkg::ST_ADD_WR;
			end
			mdn_pkg::ST_ADD_WR: begin
				wen   = 1'b1;
				waddr = AW'(idx_q);
				wdata = mdn_pkg::resolve(add_sum, mode_q);
				if (add_next > SPAN_W) begin
					if (offset_q == AW'(1)) begin
						state_d = mdn_pkg::ST_SERVE;
					end else begin
						state_d = mdn_pkg::ST_MID_RDL;
					end
				end else begin
					state_d = mdn_pkg::ST_ADD_RD;
				end
			end
			mdn_pkg::ST_SERVE: begin
				ren   = serve_ren;
				raddr = pos_q + AW'(iss_q);
				if (iss_q == n_q && !s1_valid_q) begin
					state_d = mdn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdn_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration and generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			mode_q  <= '0;
			hurst_q <= mdn_pkg::HURST_RESET;
			gen_q   <= '{mdn_pkg::SEED_RESET, mdn_pkg::SEED_RESET, mdn_pkg::SEED_RESET};
		end else begin
			if (draw) begin
				gen_q <= mdn_pkg::taus_next(gen_q);
			end
			if (cfg_valid) begin
				case (cfg_index)
					mdn_pkg::REG_MASK_BITS:     mask_q   <= cfg_data[4:0];
					mdn_pkg::REG_OVERFLOW_MODE: mode_q   <= cfg_data[1:0];
					mdn_pkg::REG_HURST_FACTOR:  hurst_q  <= cfg_data[16:0];
					mdn_pkg::REG_SEED_ONE:      gen_q.s1 <= cfg_data;
					mdn_pkg::REG_SEED_TWO:      gen_q.s2 <= cfg_data;
					mdn_pkg::REG_SEED_THREE:    gen_q.s3 <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Regeneration datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_q <= 1'b0;
			scale_q      <= mdn_pkg::SCALE_HALF;
			offset_q     <= OFS_TOP;
			idx_q        <= WW'(OFS_TOP);
		end else begin
			case (state_q)
				mdn_pkg::ST_RG_END: begin
					tail_valid_q <= 1'b1;
					scale_q      <= mdn_pkg::SCALE_HALF;
					offset_q     <= OFS_TOP;
					idx_q        <= WW'(OFS_TOP);
				end
				mdn_pkg::ST_MID_WR: begin
					idx_q <= mid_next;
				end
				mdn_pkg::ST_SCALE: begin
					scale_q <= scale_prod[47:16];
					idx_q   <= WW'(offset_q);
				end
				mdn_pkg::ST_ADD_WR: begin
					if (add_next > SPAN_W) begin
						// Drop to the next level: its first midpoint is the new offset.
						offset_q <= offset_q >> 1;
						idx_q    <= WW'(offset_q >> 1);
					end else begin
						idx_q <= add_next;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mdn_pkg::ST_MID_RDR) begin
			left_q <= mdn_pkg::half(rdata_q);
		end
		if (state_q == mdn_pkg::ST_ADD_RD) begin
			rand_q <= new_word;
		end
		if (state_q == mdn_pkg::ST_ADD_MUL) begin
			prod_q <= rand_prod[63:32];
		end
	end

	// Request bookkeeping, read stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= ADDR_END;
			n_q         <= '0;
			iss_q       <= '0;
			s1_valid_q  <= 1'b0;
			s1_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (state_q == mdn_pkg::ST_IDLE && in_valid) begin
				n_q   <= n_in;
				iss_q <= '0;
			end
			if (state_q == mdn_pkg::ST_ADD_WR && add_next > SPAN_W && offset_q == AW'(1)) begin
				pos_q <= '0;
			end
			if (state_q == mdn_pkg::ST_SERVE && iss_q == n_q && !s1_valid_q) begin
				pos_q <= pos_q + AW'(n_q);
			end
			if (serve_ren) begin
				iss_q      <= iss_q + 7'd1;
				s1_valid_q <= 1'b1;
				s1_last_q  <= (iss_q + 7'd1 == n_q);
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				last_q      <= s1_last_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			sample_q <= mdn_pkg::mask_sample(rdata_q, mask_q);
		end
	end

endmodule

@@ test/midpoint_displacement_noise_test.sv @@
// Self-checking testbench of the midpoint displacement noise source.
// Depends on mdn_pkg and midpoint_displacement_noise; holds its own model of the buffer.
module midpoint_displacement_noise_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPAN       = 4096;
	localparam int VEC_MAX    = 64;
	localparam int IDLE_WAIT  = 40;
	localparam int CYCLE_CAP  = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [6:0]  vector_size = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] sample;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	midpoint_displacement_noise dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .vector_size(vector_size),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Model state: noise buffer, read pointer, generator and registers.
	logic [31:0] noise_model [0:SPAN];
	int unsigned read_ptr;
	logic [31:0] gen_s1, gen_s2, gen_s3;
	logic [31:0] scale_q32;
	logic [4:0]  m_mask;
	logic [1:0]  m_ovf;
	logic [16:0] m_hurst;

	// Expected samples and last flags, oldest first.
	logic [31:0] want_sample [$];
	logic        want_last [$];

	int errors = 0;
	int cycles = 0;
	bit no_gap = 0;
	bit no_stall = 0;

	function automatic longint to_signed(logic [31:0] u);
		return longint'($signed(u));
	endfunction

	// Advance the three Taus88 components and return the combined word.
	function automatic logic [31:0] draw_word();
		logic [31:0] b;
		b = ((gen_s1 << 13) ^ gen_s1) >> 19;
		gen_s1 = ((gen_s1 & 32'hFFFF_FFFE) << 12) ^ b;
		b = ((gen_s2 << 2) ^ gen_s2) >> 25;
		gen_s2 = ((gen_s2 & 32'hFFFF_FFF8) << 4) ^ b;
		b = ((gen_s3 << 3) ^ gen_s3) >> 11;
		gen_s3 = ((gen_s3 & 32'hFFFF_FFF0) << 17) ^ b;
		return gen_s1 ^ gen_s2 ^ gen_s3;
	endfunction

	// Random word times scale, magnitude truncated, sign put back after.
	function automatic longint displaced_random();
		longint r;
		longint unsigned mag, p;
		r = to_signed(draw_word());
		mag = (r < 0) ? longint'(-r) : r;
		p = (mag * longint'(scale_q32)) >> 32;
		return (r < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic [31:0] fold_sum(longint t);
		if (t > 64'sd2147483647 || t < -64'sd2147483648) begin
			if (m_ovf == mdn_pkg::OVF_SATURATE)
				return (t > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			if (m_ovf == mdn_pkg::OVF_WRAP)
				return t[31:0];
			return 32'h8000_0000;
		end
		return t[31:0];
	endfunction

	// Rebuild the whole buffer level by level.
	function automatic void rebuild_buffer();
		longint unsigned hf;
		int stride, offset, i;
		longint a, b;
		hf = (m_hurst > mdn_pkg::HURST_ONE) ? 65536 : m_hurst;
		stride = SPAN / 2;
		offset = stride / 2;
		noise_model[0] = noise_model[SPAN];
		noise_model[SPAN / 2] = 32'(to_signed(draw_word()) / 4);
		noise_model[SPAN] = 32'(to_signed(draw_word()) / 4);
		scale_q32 = mdn_pkg::SCALE_HALF;
		while (offset > 0) begin
			for (i = offset; i + offset <= SPAN; i += stride) begin
				a = to_signed(noise_model[i - offset]) / 2;
				b = to_signed(noise_model[i + offset]) / 2;
				noise_model[i] = 32'(a + b);
			end
			scale_q32 = 32'((longint'(scale_q32) * hf) >> 16);
			for (i = offset; i <= SPAN; i += offset)
				noise_model[i] = fold_sum(to_signed(noise_model[i]) + displaced_random());
			stride = offset;
			offset /= 2;
		end
		read_ptr = 0;
	endfunction

	// Queue the samples that one request of size n must produce.
	function automatic void predict_vector(logic [6:0] req);
		int n, k;
		logic [31:0] m, s;
		n = int'(req);
		if (n == 0)
			return;
		if (n > VEC_MAX)
			n = VEC_MAX;
		if (read_ptr + n > SPAN)
			rebuild_buffer();
		m = 32'hFFFF_FFFF << m_mask;
		for (k = 0; k < n; k++) begin
			s = noise_model[read_ptr + k];
			if (m_mask != 0)
				s = (s & m) + ((~m) >> 1);
			want_sample.push_back(s);
			want_last.push_back(k + 1 == n);
		end
		read_ptr += n;
	endfunction

	function automatic void model_reset();
		foreach (noise_model[i])
			noise_model[i] = '0;
		read_ptr = SPAN;
		m_mask = '0;
		m_ovf = '0;
		m_hurst = mdn_pkg::HURST_RESET;
		gen_s1 = mdn_pkg::SEED_RESET;
		gen_s2 = mdn_pkg::SEED_RESET;
		gen_s3 = mdn_pkg::SEED_RESET;
		scale_q32 = mdn_pkg::SCALE_HALF;
	endfunction

	// Hold the request after a random gap until the block takes it, then predict.
	// Valid is left high; the next call lowers it only for a gap, the drain always does.
	task automatic send_request(logic [6:0] n);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		vector_size <= n;
		do @(posedge clk); while (!in_ready);
		predict_vector(n);
		@(negedge clk);
	endtask

	// Drop the request line and let every expected sample drain, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (want_sample.size() != 0)
			@(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mdn_pkg::REG_MASK_BITS:     m_mask = data[4:0];
			mdn_pkg::REG_OVERFLOW_MODE: m_ovf = data[1:0];
			mdn_pkg::REG_HURST_FACTOR:  m_hurst = data[16:0];
			mdn_pkg::REG_SEED_ONE:      gen_s1 = data;
			mdn_pkg::REG_SEED_TWO:      gen_s2 = data;
			mdn_pkg::REG_SEED_THREE:    gen_s3 = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: hold out_ready low for a random gap before each transfer, unless no_stall is set.
	initial begin
		int k;
		@(negedge clk);
		forever begin
			k = no_stall ? 0 : $urandom_range(0, 6);
			if (k > 0) begin
				out_ready <= 1'b0;
				repeat (k) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Compare each output transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (want_sample.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample: expected none, actual %h last %b",
					$time, sample, last);
			end else begin
				if (sample !== want_sample[0]) begin
					errors++;
					$display("%0t: sample mismatch: expected %h, actual %h",
						$time, want_sample[0], sample);
				end
				if (last !== want_last[0]) begin
					errors++;
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, want_last[0], last);
				end
				void'(want_sample.pop_front());
				void'(want_last.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("midpoint_displacement_noise_test failed");
			$finish;
		end
	end

	// Reset state: first request regenerates; zero size, full and clamped sizes.
	task automatic test_reset_values();
		send_request(7'd1);
		send_request(7'd64);
		send_request(7'd0);
		send_request(7'd127);
		send_request(7'd65);
		send_request(7'd2);
		drain();
	endtask

	// Mask extremes and each overflow mode.
	task automatic test_mask_and_overflow();
		write_reg(mdn_pkg::REG_MASK_BITS, 32'd31);
		write_reg(mdn_pkg::REG_OVERFLOW_MODE, 32'(mdn_pkg::OVF_SATURATE));
		write_reg(mdn_pkg::REG_HURST_FACTOR, 32'(mdn_pkg::HURST_ONE));
		send_request(7'd63);
		send_request(7'd5);
		drain();
		write_reg(mdn_pkg::REG_MASK_BITS, 32'd1);
		write_reg(mdn_pkg::REG_OVERFLOW_MODE, 32'(mdn_pkg::OVF_WRAP));
		send_request(7'd64);
		drain();
		write_reg(mdn_pkg::REG_MASK_BITS, 32'd0);
		write_reg(mdn_pkg::REG_OVERFLOW_MODE, 32'd2);
		send_request(7'd33);
		drain();
	endtask

	// Hurst above one, zero hurst, seeds at and below their minimum.
	task automatic test_hurst_and_seeds();
		write_reg(mdn_pkg::REG_HURST_FACTOR, 32'h1FFFF);
		write_reg(mdn_pkg::REG_SEED_ONE, 32'hFFFF_FFFF);
		write_reg(mdn_pkg::REG_SEED_TWO, 32'd8);
		write_reg(mdn_pkg::REG_SEED_THREE, 32'd16);
		send_request(7'd64);
		send_request(7'd1);
		drain();
		write_reg(mdn_pkg::REG_HURST_FACTOR, 32'd0);
		write_reg(mdn_pkg::REG_SEED_ONE, 32'd0);
		write_reg(mdn_pkg::REG_SEED_TWO, 32'd3);
		write_reg(mdn_pkg::REG_SEED_THREE, 32'hFFFF_FFFF);
		send_request(7'd64);
		send_request(7'd17);
		drain();
	endtask

	function automatic logic [6:0] random_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return 7'd0;
		if (r < 8)
			return 7'($urandom_range(65, 127));
		if (r < 20)
			return 7'd64;
		if (r < 50)
			return 7'($urandom_range(1, 8));
		return 7'($urandom_range(1, 64));
	endfunction

	// Random phases, each under fresh settings; large requests push through rebuilds.
	task automatic test_random_traffic();
		int phase, i, pick;
		logic [31:0] hf;
		for (phase = 0; phase < 6; phase++) begin
			write_reg(mdn_pkg::REG_MASK_BITS,
				$urandom_range(0, 1) ? 32'($urandom_range(0, 31)) : 32'd0);
			write_reg(mdn_pkg::REG_OVERFLOW_MODE, $urandom_range(0, 3));
			pick = $urandom_range(0, 3);
			hf = (pick == 0) ? 32'(mdn_pkg::HURST_ONE)
				: (pick == 1) ? 32'($urandom_range(0, 131071))
				: 32'($urandom_range(30000, 65536));
			write_reg(mdn_pkg::REG_HURST_FACTOR, hf);
			if ($urandom_range(0, 1)) begin
				write_reg(mdn_pkg::REG_SEED_ONE, $urandom | 32'd2);
				write_reg(mdn_pkg::REG_SEED_TWO, $urandom | 32'd8);
				write_reg(mdn_pkg::REG_SEED_THREE, $urandom | 32'd16);
			end
			no_gap = ($urandom_range(0, 3) == 0);
			no_stall = ($urandom_range(0, 3) == 0);
			for (i = 0; i < 80; i++)
				send_request(random_size());
			drain();
		end
		no_gap = 0;
		no_stall = 0;
	endtask

	initial begin
		model_reset();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_values();
		test_mask_and_overflow();
		test_hurst_and_seeds();
		test_random_traffic();
		if (errors == 0)
			$display("midpoint_displacement_noise_test passed");
		else
			$display("midpoint_displacement_noise_test failed");
		$finish;
	end

endmodule
